>>> rtl/core/assert_macros.svh
// assertion macros used by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("implication check failed");

`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("next cycle check failed");

`endif

>>> rtl/core/srma_pkg.sv
// types and constants of the sparse row merge accumulator
// no dependencies
package srma_pkg;

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_POP    = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic [2:0]         list_select;
		logic [15:0]        column;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [15:0]        out_column;
		logic signed [31:0] out_sum;
		logic               saturated;
	} out_item_t;

	typedef struct packed {
		logic append;
		logic clear;
		logic pop_init;
		logic rd;
		logic scan_upd;
		logic absorb;
		logic load_imm;
		logic load_pop;
	} cmd_t;

	typedef struct packed {
		logic head_ok;
		logic col_less;
		logic col_eq;
		logic found;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/core/srma_dp.sv
// datapath: list memory, counters, head compare, accumulator, output register
// depends on srma_pkg
module srma_dp #(
	parameter int NUM_LISTS   = 8,
	parameter int LIST_DEPTH  = 64,
	parameter int COLUMN_BITS = 16,
	parameter int VALUE_BITS  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  srma_pkg::in_item_t           in_data,
	input  srma_pkg::cmd_t               cmd,
	input  logic [$clog2(NUM_LISTS)-1:0] lidx,
	output srma_pkg::sts_t               sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output srma_pkg::out_item_t          out_data
);
	import srma_pkg::*;

	localparam int LW = $clog2(NUM_LISTS);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int TOT = NUM_LISTS * LIST_DEPTH;
	localparam int AW = $clog2(TOT);
	localparam int EW = COLUMN_BITS + VALUE_BITS;
	localparam logic signed [63:0] ACC_MAX = 64'sh7fffffffffffffff;
	localparam logic signed [63:0] ACC_MIN = 64'sh8000000000000000;
	localparam logic signed [63:0] OUT_MAX = 64'sh000000007fffffff;
	localparam logic signed [63:0] OUT_MIN = 64'shffffffff80000000;

	logic [EW-1:0]          mem [TOT];
	logic [EW-1:0]          rd_q;
	logic [CW-1:0]          wcnt_q [NUM_LISTS];
	logic [CW-1:0]          rpos_q [NUM_LISTS];
	logic [COLUMN_BITS-1:0] best_q;
	logic                   found_q;
	logic signed [63:0]     acc_q;
	logic                   out_valid_q;
	out_item_t              out_q;

	logic [63:0]             sel_w;
	logic [LW-1:0]           sel;
	logic                    drop;
	logic [47:0]             col_w;
	logic [63:0]             val_w;
	logic [AW-1:0]           wr_addr;
	logic [AW-1:0]           rd_addr;
	logic [COLUMN_BITS-1:0]  rd_col;
	logic signed [VALUE_BITS-1:0] rd_val;
	logic signed [63:0]      addend;
	logic signed [63:0]      sum;
	logic [47:0]             best_w;
	out_item_t               out_d;

	always_comb begin
		sel_w   = 64'(in_data.list_select);
		sel     = sel_w[LW-1:0];
		drop    = (sel_w >= 64'(NUM_LISTS)) || (wcnt_q[sel] >= CW'(LIST_DEPTH));
		col_w   = 48'(in_data.column);
		val_w   = 64'(unsigned'(in_data.value));
		wr_addr = AW'(32'(sel) * LIST_DEPTH) + AW'(wcnt_q[sel]);
		rd_addr = AW'(32'(lidx) * LIST_DEPTH) + AW'(rpos_q[lidx]);
		rd_col  = rd_q[EW-1:VALUE_BITS];
		rd_val  = rd_q[VALUE_BITS-1:0];
		addend  = 64'(rd_val);
		sum     = acc_q + addend;
		if (!acc_q[63] && !addend[63] && sum[63]) begin
			sum = ACC_MAX;
		end else if (acc_q[63] && addend[63] && !sum[63]) begin
			sum = ACC_MIN;
		end
		best_w  = 48'(best_q);
	end

	// next result word: immediate status, empty status or merged entry
	always_comb begin
		out_d = '0;
		if (cmd.load_imm) begin
			out_d.status = (cmd.append && drop) ? ST_DROPPED : ST_OK;
		end else if (!found_q) begin
			out_d.status = ST_EMPTY;
		end else begin
			out_d.out_column = best_w[15:0];
			if (acc_q > OUT_MAX) begin
				out_d.out_sum   = OUT_MAX[31:0];
				out_d.saturated = 1'b1;
			end else if (acc_q < OUT_MIN) begin
				out_d.out_sum   = OUT_MIN[31:0];
				out_d.saturated = 1'b1;
			end else begin
				out_d.out_sum = acc_q[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append && !drop) begin
			mem[wr_addr] <= {col_w[COLUMN_BITS-1:0], val_w[VALUE_BITS-1:0]};
		end
		if (cmd.rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LISTS; i++) begin
				wcnt_q[i] <= '0;
				rpos_q[i] <= '0;
			end
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				for (int i = 0; i < NUM_LISTS; i++) begin
					wcnt_q[i] <= '0;
					rpos_q[i] <= '0;
				end
			end
			if (cmd.append && !drop) begin
				wcnt_q[sel] <= wcnt_q[sel] + 1'b1;
			end
			if (cmd.absorb) begin
				rpos_q[lidx] <= rpos_q[lidx] + 1'b1;
			end
			if (cmd.pop_init) begin
				found_q <= 1'b0;
			end else if (cmd.scan_upd && sts.col_less) begin
				found_q <= 1'b1;
			end
			if (cmd.load_imm || cmd.load_pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop_init) begin
			acc_q <= '0;
		end else if (cmd.absorb) begin
			acc_q <= sum;
		end
		if (cmd.scan_upd && sts.col_less) begin
			best_q <= rd_col;
		end
		if (cmd.load_imm || cmd.load_pop) begin
			out_q <= out_d;
		end
	end

	assign sts.head_ok  = rpos_q[lidx] < wcnt_q[lidx];
	assign sts.col_less = !found_q || (rd_col < best_q);
	assign sts.col_eq   = rd_col == best_q;
	assign sts.found    = found_q;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule

>>> rtl/core/srma_ctrl.sv
// controller: sequences append, clear, unused modes and the two-pass pop over the lists
// depends on srma_pkg
module srma_ctrl #(
	parameter int NUM_LISTS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   mode,
	input  srma_pkg::sts_t               sts,
	output srma_pkg::cmd_t               cmd,
	output logic [$clog2(NUM_LISTS)-1:0] lidx
);
	import srma_pkg::*;

	localparam int LW = $clog2(NUM_LISTS);
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_SCAN_CMP = 3'd2;
	localparam logic [2:0] S_ABS      = 3'd3;
	localparam logic [2:0] S_ABS_CMP  = 3'd4;
	localparam logic [2:0] S_SCAN_END = 3'd5;
	localparam logic [2:0] S_FIN      = 3'd6;

	logic [2:0]    state_q, state_d;
	logic [LW-1:0] lidx_q, lidx_d;
	logic          last;
	logic          accept;

	assign last     = lidx_q == LW'(NUM_LISTS - 1);
	assign in_ready = (state_q == S_IDLE) && sts.out_free;
	assign accept   = in_valid && in_ready;
	assign lidx     = lidx_q;

	always_comb begin
		state_d = state_q;
		lidx_d  = lidx_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mode == MODE_POP) begin
						cmd.pop_init = 1'b1;
						lidx_d       = '0;
						state_d      = S_SCAN;
					end else begin
						cmd.load_imm = 1'b1;
						cmd.append   = mode == MODE_APPEND;
						cmd.clear    = mode == MODE_CLEAR;
					end
				end
			end
			S_SCAN: begin
				if (sts.head_ok) begin
					cmd.rd  = 1'b1;
					state_d = S_SCAN_CMP;
				end else if (last) begin
					state_d = S_SCAN_END;
				end else begin
					lidx_d = lidx_q + 1'b1;
				end
			end
			S_SCAN_CMP: begin
				cmd.scan_upd = 1'b1;
				if (last) begin
					state_d = S_SCAN_END;
				end else begin
					lidx_d  = lidx_q + 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN_END: begin
				lidx_d  = '0;
				state_d = sts.found ? S_ABS : S_FIN;
			end
			S_ABS: begin
				if (sts.head_ok) begin
					cmd.rd  = 1'b1;
					state_d = S_ABS_CMP;
				end else if (last) begin
					state_d = S_FIN;
				end else begin
					lidx_d = lidx_q + 1'b1;
				end
			end
			S_ABS_CMP: begin
				if (sts.col_eq) begin
					cmd.absorb = 1'b1;
					state_d    = S_ABS;
				end else if (last) begin
					state_d = S_FIN;
				end else begin
					lidx_d  = lidx_q + 1'b1;
					state_d = S_ABS;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.load_pop = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lidx_q  <= '0;
		end else begin
			state_q <= state_d;
			lidx_q  <= lidx_d;
		end
	end

endmodule

>>> rtl/core/sparse_row_merge_accumulate.sv
// Merges NUM_LISTS column-sorted lists of (column, value) pairs and sums equal
// columns. Append, clear and unused modes are done on acceptance and load their
// status straight into the output register. A pop reads list heads through the
// single read port of the list memory, with a read state and a compare state per
// non-empty head: a scan pass over all lists finds the smallest column, then an
// absorb pass takes every head with that column. The result waits in an output
// register.
// depends on srma_pkg, srma_ctrl, srma_dp and assert_macros.svh
module sparse_row_merge_accumulate #(
	parameter int NUM_LISTS   = 8,
	parameter int LIST_DEPTH  = 64,
	parameter int COLUMN_BITS = 16,
	parameter int VALUE_BITS  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  srma_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output srma_pkg::out_item_t out_data
);
	import srma_pkg::*;
`include "assert_macros.svh"

	cmd_t                         cmd;
	sts_t                         sts;
	logic [$clog2(NUM_LISTS)-1:0] lidx;

	srma_ctrl #(
		.NUM_LISTS(NUM_LISTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (in_data.mode),
		.sts      (sts),
		.cmd      (cmd),
		.lidx     (lidx)
	);

	srma_dp #(
		.NUM_LISTS  (NUM_LISTS),
		.LIST_DEPTH (LIST_DEPTH),
		.COLUMN_BITS(COLUMN_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.lidx     (lidx),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	`ASSERT_IMPLY(a_ready_out_free, clk, arst_n, in_ready && out_valid, out_ready)
	`ASSERT_IMPLY(a_empty_zero, clk, arst_n, out_valid && out_data.status == ST_EMPTY, out_data.out_sum == 32'sd0 && out_data.saturated == 1'b0)
	`ASSERT_IMPLY(a_sat_ok, clk, arst_n, out_valid && out_data.saturated, out_data.status == ST_OK)
	`ASSERT_NEXT(a_pop_busy, clk, arst_n, cmd.pop_init, !in_ready)

endmodule

>>> tb/sv/sparse_row_merge_accumulate_checker.sv
// checker for the sparse row merge accumulator: watches both channels,
// predicts every result with its own list model and compares field by field
// depends on srma_pkg
module sparse_row_merge_accumulate_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  srma_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  srma_pkg::out_item_t out_data,
	output int                  errors,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import srma_pkg::*;

	localparam int LISTS = 8;
	localparam int DEPTH = 64;

	logic [15:0]        col_mem [LISTS][DEPTH];
	logic signed [31:0] val_mem [LISTS][DEPTH];
	int                 wr_cnt [LISTS];
	int                 rd_pos [LISTS];
	out_item_t          merged_q [$];

	assign pending = merged_q.size();

	function automatic out_item_t merge_step(in_item_t t);
		out_item_t r;
		logic [15:0] best;
		bit found;
		longint acc;
		int l;
		r = '0;
		found = 0;
		best = '0;
		acc = 0;
		if (t.mode == MODE_APPEND) begin
			l = t.list_select;
			if (wr_cnt[l] >= DEPTH) begin
				r.status = ST_DROPPED;
			end else begin
				col_mem[l][wr_cnt[l]] = t.column;
				val_mem[l][wr_cnt[l]] = t.value;
				wr_cnt[l]++;
			end
		end else if (t.mode == MODE_POP) begin
			for (l = 0; l < LISTS; l++)
				if (rd_pos[l] < wr_cnt[l] && (!found || col_mem[l][rd_pos[l]] < best)) begin
					best = col_mem[l][rd_pos[l]];
					found = 1;
				end
			if (!found) begin
				r.status = ST_EMPTY;
			end else begin
				for (l = 0; l < LISTS; l++)
					while (rd_pos[l] < wr_cnt[l] && col_mem[l][rd_pos[l]] == best) begin
						acc += val_mem[l][rd_pos[l]];
						rd_pos[l]++;
					end
				if (acc > 64'sd2147483647) begin
					acc = 64'sd2147483647;
					r.saturated = 1;
				end else if (acc < -64'sd2147483648) begin
					acc = -64'sd2147483648;
					r.saturated = 1;
				end
				r.out_column = best;
				r.out_sum = acc[31:0];
			end
		end else if (t.mode == MODE_CLEAR) begin
			for (l = 0; l < LISTS; l++) begin
				wr_cnt[l] = 0;
				rd_pos[l] = 0;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			errors = 0;
			merged_q.delete();
			for (int l = 0; l < LISTS; l++) begin
				wr_cnt[l] = 0;
				rd_pos[l] = 0;
			end
		end else begin
			if (out_valid && out_ready) begin
				if (merged_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected transaction: %p", out_data);
				end else begin
					e = merged_q.pop_front();
					if (e.status !== out_data.status || e.out_column !== out_data.out_column
							|| e.out_sum !== out_data.out_sum
							|| e.saturated !== out_data.saturated) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p actual %p", e, out_data);
					end
				end
			end
			if (in_valid && in_ready)
				merged_q.insert(merged_q.size(), merge_step(in_data));
		end
	end
endmodule

>>> tb/sv/sparse_row_merge_accumulate_test.sv
// top of the sparse row merge accumulator testbench: clock, reset, stimulus
// and verdict; depends on srma_pkg, the block and its checker
module sparse_row_merge_accumulate_test;
	timeunit 1ns;
	timeprecision 1ps;
	import srma_pkg::*;

	localparam logic [1:0] MODE_IGNORED = 2'd3;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 0;
	out_item_t out_data;
	int        errors;
	int        pending;
	int        cycles = 0;
	bit        quiet = 0;
	int        fill [8];

	always #5 clk = ~clk;

	sparse_row_merge_accumulate uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	sparse_row_merge_accumulate_checker chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data), .errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver stalls in bursts
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 0;
				n = $urandom_range(1, 16);
				repeat (n) @(negedge clk);
				out_ready <= 1;
			end else begin
				out_ready <= 1;
			end
		end
	end

	task automatic send(logic [1:0] m, logic [2:0] s, logic [15:0] c, logic [31:0] v);
		in_item_t t;
		int n;
		if (!quiet && $urandom_range(0, 6) == 0) begin
			in_valid <= 0;
			n = $urandom_range(1, 16);
			repeat (n) @(negedge clk);
		end
		t.mode = m;
		t.list_select = s;
		t.column = c;
		t.value = v;
		in_data <= t;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		if (m == MODE_APPEND && fill[s] < 64) fill[s]++;
		if (m == MODE_CLEAR) foreach (fill[i]) fill[i] = 0;
	endtask

	initial begin
		logic [15:0] base;
		int k;
		foreach (fill[i]) fill[i] = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: empty pop, extremes, saturation, unsorted, full list, mode three
		send(MODE_POP, 0, 0, 0);
		send(MODE_APPEND, 0, 16'hffff, 32'h7fffffff);
		send(MODE_APPEND, 7, 16'hffff, 32'h7fffffff);
		send(MODE_APPEND, 3, 16'h0000, 32'h80000000);
		send(MODE_APPEND, 5, 16'h0000, 32'h80000000);
		send(MODE_APPEND, 5, 16'h0000, 32'hffffffff);
		send(MODE_APPEND, 1, 16'h0005, 32'h00010000);
		send(MODE_APPEND, 1, 16'h0002, 32'hfffe0000);
		send(MODE_POP, 0, 0, 0);
		send(MODE_POP, 0, 0, 0);
		send(MODE_POP, 0, 0, 0);
		send(MODE_POP, 0, 0, 0);
		send(MODE_POP, 0, 0, 0);
		send(MODE_IGNORED, 7, 16'hffff, 32'hffffffff);
		send(MODE_CLEAR, 0, 0, 0);
		for (int i = 0; i < 65; i++) send(MODE_APPEND, 2, 16'(i), $urandom);
		send(MODE_POP, 0, 0, 0);
		send(MODE_CLEAR, 0, 0, 0);
		// random: sorted rows of appends then pops, with some noise
		k = 0;
		while (k < 1300) begin
			base = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40));
			if (k > 1100) quiet = 1;
			for (int i = 0; i < $urandom_range(4, 30); i++) begin
				int s;
				s = $urandom_range(0, 7);
				if ($urandom_range(0, 9) == 0)
					send(MODE_APPEND, 3'(s), 16'($urandom), $urandom);
				else begin
					if (base < 16'hfff0 && $urandom_range(0, 1)) base += $urandom_range(0, 2);
					send(MODE_APPEND, 3'(s), base,
						$urandom_range(0, 3) == 0 ? {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'($urandom)}
						: $urandom);
				end
				k++;
			end
			for (int i = 0; i < $urandom_range(5, 35); i++) begin
				send(MODE_POP, 0, 0, 0);
				k++;
			end
			if ($urandom_range(0, 4) == 0) begin
				send($urandom_range(0, 1) ? MODE_CLEAR : MODE_IGNORED, 3'($urandom),
					16'($urandom), $urandom);
				k++;
			end
		end
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
